@@ src/sbmc_pkg.sv @@
package sbmc_pkg;

   // Sizes of the bone table and of one matrix.
   localparam int MAX_BONES  = 64;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int BONE_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int ELEM_W     = 4;
   localparam int MAT_ADDR_W = BONE_W + ELEM_W;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W - FRAC_BITS + 2;

   // Request codes.
   localparam logic [2:0] REQ_RELATION = 3'd0;
   localparam logic [2:0] REQ_OWN      = 3'd1;
   localparam logic [2:0] REQ_FORM     = 3'd2;
   localparam logic [2:0] REQ_COMPUTE  = 3'd3;
   localparam logic [2:0] REQ_READ     = 3'd4;

   // Response status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PARENT,
      ST_MUL,
      ST_COPY,
      ST_FINISH
   } state_type;

   // Which product the sequencer is working on.
   typedef enum logic [1:0] {
      PH_ROOT,
      PH_CHAIN,
      PH_OWN
   } phase_type;

   // Control travelling alongside the operands into the multiply unit.
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [ELEM_W-1:0] elem;
   } mac_ctrl_type;

endpackage

@@ src/skeleton_bone_matrix_chain.sv @@
// Loads answer in the cycle after acceptance; a read answers through the read state and
// the response register. Loads are taken one request every cycle while the response is
// not stalled; a read holds off the next request while it is in the read state.
// A compute of n matrices (at least one) answers through the finish state; each product
// issues its steps, drains the pipeline and copies back; a chained bone reads its parent first.
// Reset is synchronous: afterwards the palette memory is cleared, during which no request is accepted.
module skeleton_bone_matrix_chain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sbmc_pkg::COUNT_W-1:0]        csr_bone_count,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_type,
   input  logic [sbmc_pkg::BONE_W-1:0]         req_bone_index,
   input  logic [sbmc_pkg::ELEM_W-1:0]         req_element_index,
   input  logic signed [sbmc_pkg::DATA_W-1:0]  req_element_value,
   input  logic [sbmc_pkg::BONE_W-1:0]         req_parent_bone,
   input  logic [sbmc_pkg::COUNT_W-1:0]        req_matrix_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic signed [sbmc_pkg::DATA_W-1:0]  rsp_read_value
);
   import sbmc_pkg::*;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [COUNT_W-1:0]     bone_count_ff;
   logic [COUNT_W-1:0]     nb;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     bone_ff, bone_in;
   logic [COUNT_W-1:0]     bone_next;
   logic [COUNT_W-1:0]     mcount_min;
   logic [COUNT_W-1:0]     iss_ff, iss_in;
   logic [ELEM_W-1:0]      copy_ff, copy_in;
   logic [MAT_ADDR_W-1:0]  clr_ff, clr_in;
   logic                   rd_ok_ff, rd_ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                   accept;
   logic                   bone_ok, parent_ok;
   logic                   issue;
   mac_ctrl_type           ctrl_in, ctrl_ff;
   logic                   mac_done;
   logic [DATA_W-1:0]      copy_data;
   logic [1:0]             k_idx;
   logic [ELEM_W-1:0]      e_idx;
   logic [BONE_W-1:0]      a_bone;
   logic [BONE_W-1:0]      parent_q;
   logic [MAT_ADDR_W-1:0]  a_addr, b_addr, host_addr;
   logic [DATA_W-1:0]      pal_q, form_q, rel_q, own_q;
   logic [DATA_W-1:0]      a_data, b_data;
   logic                   pal_we, pal_re;
   logic [MAT_ADDR_W-1:0]  pal_waddr, pal_raddr;
   logic [DATA_W-1:0]      pal_wdata;
   logic                   rel_we, own_we, form_we;

   // Request acceptance and range checks.
   always_comb begin
      nb         = (bone_count_ff > COUNT_W'(MAX_BONES)) ? COUNT_W'(MAX_BONES) : bone_count_ff;
      req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept     = req_valid && !req_stall;
      bone_ok    = {1'b0, req_bone_index} < nb;
      parent_ok  = {1'b0, req_parent_bone} < nb;
      mcount_min = (req_matrix_count < nb) ? req_matrix_count : nb;
      host_addr  = {req_bone_index, req_element_index};
      rel_we     = accept && (req_type == REQ_RELATION) && bone_ok && parent_ok;
      own_we     = accept && (req_type == REQ_OWN) && bone_ok;
      form_we    = accept && (req_type == REQ_FORM);
      bone_next  = bone_ff + COUNT_W'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_type == REQ_READ) begin
               state_in = ST_READ;
            end else if (accept && req_type == REQ_COMPUTE && nb != '0) begin
               state_in = ST_MUL;
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_PARENT: state_in = ST_MUL;
         ST_MUL: begin
            if (mac_done) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (&copy_ff) begin
               unique case (phase_ff)
                  PH_ROOT:  state_in = (count_ff > COUNT_W'(1)) ? ST_PARENT : ST_FINISH;
                  PH_CHAIN: state_in = (bone_next < count_ff) ? ST_PARENT : ST_MUL;
                  PH_OWN:   state_in = (bone_next < count_ff) ? ST_MUL : ST_FINISH;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer counters and phase.
   always_comb begin
      phase_in = phase_ff;
      bone_in  = bone_ff;
      count_in = count_ff;
      iss_in   = iss_ff;
      copy_in  = '0;
      clr_in   = clr_ff + MAT_ADDR_W'(1);
      rd_ok_in = rd_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            phase_in = PH_ROOT;
            bone_in  = '0;
            count_in = mcount_min;
            iss_in   = '0;
            rd_ok_in = bone_ok;
         end
         ST_PARENT: iss_in = '0;
         ST_MUL: begin
            if (issue) begin
               iss_in = iss_ff + COUNT_W'(1);
            end
         end
         ST_COPY: begin
            copy_in = copy_ff + ELEM_W'(1);
            iss_in  = '0;
            if (&copy_ff) begin
               unique case (phase_ff)
                  PH_ROOT: begin
                     phase_in = PH_CHAIN;
                     bone_in  = COUNT_W'(1);
                  end
                  PH_CHAIN: begin
                     if (bone_next < count_ff) begin
                        bone_in = bone_next;
                     end else begin
                        phase_in = PH_OWN;
                        bone_in  = COUNT_W'(1);
                     end
                  end
                  default: bone_in = bone_next;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Operand addressing for the multiply: element e = r*4+c, step k.
   always_comb begin
      issue   = (state_ff == ST_MUL) && !iss_ff[COUNT_W-1];
      e_idx   = iss_ff[COUNT_W-2:2];
      k_idx   = iss_ff[1:0];
      a_bone  = (phase_ff == PH_CHAIN) ? parent_q : bone_ff[BONE_W-1:0];
      a_addr  = {a_bone, e_idx[3:2], k_idx};
      b_addr  = {bone_ff[BONE_W-1:0], k_idx, e_idx[1:0]};
      ctrl_in.valid = issue;
      ctrl_in.first = (k_idx == 2'd0);
      ctrl_in.last  = (k_idx == 2'd3);
      ctrl_in.elem  = e_idx;
      a_data  = (phase_ff == PH_ROOT) ? form_q : pal_q;
      b_data  = (phase_ff == PH_CHAIN) ? rel_q : own_q;
   end

   // Palette memory port use: clearing, copying back, host reads, operand reads.
   always_comb begin
      pal_we    = (state_ff == ST_CLEAR) || (state_ff == ST_COPY);
      pal_waddr = (state_ff == ST_CLEAR) ? clr_ff : {bone_ff[BONE_W-1:0], copy_ff};
      pal_wdata = (state_ff == ST_CLEAR) ? '0 : copy_data;
      pal_re    = issue || (accept && req_type == REQ_READ);
      pal_raddr = (state_ff == ST_IDLE) ? host_addr : a_addr;
   end

   // Response register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (accept && req_type != REQ_READ) begin
         rsp_valid_in = (req_type != REQ_COMPUTE) || (nb == '0);
         rsp_value_in = '0;
         unique case (req_type)
            REQ_RELATION: rsp_status_in = (bone_ok && parent_ok) ? STATUS_OK : STATUS_INVALID;
            REQ_OWN:      rsp_status_in = bone_ok ? STATUS_OK : STATUS_INVALID;
            REQ_FORM:     rsp_status_in = STATUS_OK;
            default:      rsp_status_in = STATUS_INVALID;
         endcase
      end else if (state_ff == ST_READ) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rd_ok_ff ? STATUS_OK : STATUS_INVALID;
         rsp_value_in  = rd_ok_ff ? pal_q : '0;
      end else if (state_ff == ST_FINISH) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_value_in  = '0;
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         bone_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         ctrl_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctrl_ff.valid <= ctrl_in.valid;
         if (csr_write_enable) begin
            bone_count_ff <= csr_bone_count;
         end
      end
      phase_ff      <= phase_in;
      bone_ff       <= bone_in;
      count_ff      <= count_in;
      iss_ff        <= iss_in;
      copy_ff       <= copy_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      ctrl_ff.first <= ctrl_in.first;
      ctrl_ff.last  <= ctrl_in.last;
      ctrl_ff.elem  <= ctrl_in.elem;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

   // Bone table and matrix stores.
   sbmc_ram #(.WIDTH(BONE_W), .DEPTH(MAX_BONES)) u_parent (
      .clock (clock),
      .we    (rel_we),
      .waddr (req_bone_index),
      .wdata (req_parent_bone),
      .re    (state_ff == ST_PARENT),
      .raddr (bone_ff[BONE_W-1:0]),
      .rdata (parent_q)
   );

   sbmc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BONES * 16)) u_relation (
      .clock (clock),
      .we    (rel_we),
      .waddr (host_addr),
      .wdata (req_element_value),
      .re    (issue),
      .raddr (b_addr),
      .rdata (rel_q)
   );

   sbmc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BONES * 16)) u_own (
      .clock (clock),
      .we    (own_we),
      .waddr (host_addr),
      .wdata (req_element_value),
      .re    (issue),
      .raddr (b_addr),
      .rdata (own_q)
   );

   sbmc_ram #(.WIDTH(DATA_W), .DEPTH(16)) u_form (
      .clock (clock),
      .we    (form_we),
      .waddr (req_element_index),
      .wdata (req_element_value),
      .re    (issue),
      .raddr (a_addr[ELEM_W-1:0]),
      .rdata (form_q)
   );

   sbmc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BONES * 16)) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (pal_waddr),
      .wdata (pal_wdata),
      .re    (pal_re),
      .raddr (pal_raddr),
      .rdata (pal_q)
   );

   // Multiply-accumulate unit with its result buffer.
   sbmc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_ff),
      .a_data     (a_data),
      .b_data     (b_data),
      .copy_index (copy_ff),
      .copy_data  (copy_data),
      .done       (mac_done)
   );

endmodule

@@ src/sbmc_ram.sv @@
module sbmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/sbmc_mac.sv @@
module sbmc_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  sbmc_pkg::mac_ctrl_type       ctrl,
   input  logic [sbmc_pkg::DATA_W-1:0]  a_data,
   input  logic [sbmc_pkg::DATA_W-1:0]  b_data,
   input  logic [sbmc_pkg::ELEM_W-1:0]  copy_index,
   output logic [sbmc_pkg::DATA_W-1:0]  copy_data,
   output logic                         done
);
   import sbmc_pkg::*;

   mac_ctrl_type             ctrl_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  term;
   logic [DATA_W-1:0]        sat_value;
   logic [DATA_W-1:0]        temp_ff [16];
   logic                     done_ff;
   logic                     fits;

   // Product stage: one signed 32 by 32 multiply per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl.valid;
      end
      ctrl_ff.first <= ctrl.first;
      ctrl_ff.last  <= ctrl.last;
      ctrl_ff.elem  <= ctrl.elem;
      prod_ff       <= $signed(a_data) * $signed(b_data);
   end

   // Each partial product is floored before it joins the sum.
   always_comb begin
      term   = ACC_W'(prod_ff >>> FRAC_BITS);
      acc_in = (ctrl_ff.first ? '0 : acc_ff) + term;
      fits   = (&acc_in[ACC_W-1:DATA_W-1]) || !(|acc_in[ACC_W-1:DATA_W-1]);
      if (fits) begin
         sat_value = acc_in[DATA_W-1:0];
      end else if (acc_in[ACC_W-1]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // Accumulate and park finished elements in the result buffer.
   always_ff @(posedge clock) begin
      if (ctrl_ff.valid) begin
         acc_ff <= acc_in;
         if (ctrl_ff.last) begin
            temp_ff[ctrl_ff.elem] <= sat_value;
         end
      end
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctrl_ff.valid && ctrl_ff.last && (&ctrl_ff.elem);
      end
   end

   assign done      = done_ff;
   assign copy_data = temp_ff[copy_index];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import sbmc_pkg::*;

   // Request codes 5 to 7 are unused by the block.
   localparam logic [2:0] REQ_SPARE = 3'd5;

   typedef int mat_type [16];

   typedef struct {
      logic status;
      int   value;
   } reply_type;

   // Tracks the bone table and palette and holds the responses still owed.
   class palette_scoreboard;
      int unsigned bone_count;
      logic [5:0]  parent_of [64];
      mat_type     relation [64];
      mat_type     own [64];
      mat_type     palette [64];
      mat_type     form;
      logic [15:0] rel_mask [64];
      logic [15:0] own_mask [64];
      logic [15:0] form_mask;
      reply_type   pending [$];
      int          errors;

      function new();
         bone_count = 0;
         form_mask = '0;
         errors = 0;
         for (int b = 0; b < 64; b++) begin
            rel_mask[b] = '0;
            own_mask[b] = '0;
            parent_of[b] = '0;
            for (int e = 0; e < 16; e++) begin
               relation[b][e] = 0;
               own[b][e] = 0;
               palette[b][e] = 0;
            end
         end
         for (int e = 0; e < 16; e++) form[e] = 0;
      endfunction

      function int unsigned live_bones();
         return (bone_count < MAX_BONES) ? bone_count : MAX_BONES;
      endfunction

      // Length of the leading run of bones whose matrices are fully loaded.
      function int unsigned ready_bones();
         int unsigned n;
         n = 0;
         if (form_mask != 16'hFFFF) return 0;
         while (n < 64 && own_mask[n] == 16'hFFFF && (n == 0 || rel_mask[n] == 16'hFFFF))
            n++;
         return n;
      endfunction

      // Row-major fixed-point product, each partial product floored, sum saturated.
      function void product(input mat_type a, input mat_type b, output mat_type r);
         mat_type t;
         longint  acc;
         longint  p;
         for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
               acc = 0;
               for (int k = 0; k < 4; k++) begin
                  p = longint'(a[row*4+k]) * longint'(b[k*4+col]);
                  acc += p >>> FRAC_BITS;
               end
               if (acc > 64'sd2147483647) t[row*4+col] = 32'h7FFF_FFFF;
               else if (acc < -64'sd2147483648) t[row*4+col] = 32'h8000_0000;
               else t[row*4+col] = int'(acc);
            end
         end
         r = t;
      endfunction

      // Applies an accepted request and queues the response it must produce.
      function void note(logic [2:0] kind, logic [5:0] bone, logic [3:0] elem, int value,
                         logic [5:0] parent, logic [6:0] mcount);
         int unsigned nb;
         int unsigned cnt;
         reply_type   rep;
         nb = live_bones();
         rep.status = STATUS_INVALID;
         rep.value = 0;
         case (kind)
            REQ_RELATION: begin
               if (bone < nb && parent < nb) begin
                  relation[bone][elem] = value;
                  parent_of[bone] = parent;
                  rel_mask[bone][elem] = 1'b1;
                  rep.status = STATUS_OK;
               end
            end
            REQ_OWN: begin
               if (bone < nb) begin
                  own[bone][elem] = value;
                  own_mask[bone][elem] = 1'b1;
                  rep.status = STATUS_OK;
               end
            end
            REQ_FORM: begin
               form[elem] = value;
               form_mask[elem] = 1'b1;
               rep.status = STATUS_OK;
            end
            REQ_COMPUTE: begin
               if (nb > 0) begin
                  cnt = (mcount < nb) ? mcount : nb;
                  product(form, own[0], palette[0]);
                  for (int i = 1; i < cnt; i++)
                     product(palette[parent_of[i]], relation[i], palette[i]);
                  for (int i = 1; i < cnt; i++)
                     product(palette[i], own[i], palette[i]);
                  rep.status = STATUS_OK;
               end
            end
            REQ_READ: begin
               if (bone < nb) begin
                  rep.value = palette[bone][elem];
                  rep.status = STATUS_OK;
               end
            end
            default: ;
         endcase
         pending.push_back(rep);
      endfunction

      // Compares a delivered response with the oldest one owed.
      function void check(logic status, int value);
         reply_type rep;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d value %0d",
                     $time, status, value);
            errors++;
            return;
         end
         rep = pending.pop_front();
         if (status !== rep.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, rep.status, status);
            errors++;
         end
         if (value !== rep.value) begin
            $display("%0t: read value mismatch, expected %0d, actual %0d",
                     $time, rep.value, value);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [COUNT_W-1:0]        csr_bone_count;
   logic                      req_valid;
   logic                      req_stall;
   logic [2:0]                req_type;
   logic [BONE_W-1:0]         req_bone_index;
   logic [ELEM_W-1:0]         req_element_index;
   logic signed [DATA_W-1:0]  req_element_value;
   logic [BONE_W-1:0]         req_parent_bone;
   logic [COUNT_W-1:0]        req_matrix_count;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_status;
   logic signed [DATA_W-1:0]  rsp_read_value;

   palette_scoreboard sb;
   bit                quiet;

   skeleton_bone_matrix_chain uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_bone_count    (csr_bone_count),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_bone_index    (req_bone_index),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_parent_bone   (req_parent_bone),
      .req_matrix_count  (req_matrix_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side: random back-pressure before each response.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 12);
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Every delivered response is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_status, rsp_read_value);
   end

   function automatic int pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 0;
               default: return -1;
            endcase
         end
         1: return int'($urandom);
         default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
      endcase
   endfunction

   // Drives one request and waits for its acceptance; called just after a falling edge.
   task automatic send(logic [2:0] kind, logic [5:0] bone, logic [3:0] elem, int value,
                       logic [5:0] parent, logic [6:0] mcount);
      int n;
      n = quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_type = kind;
      req_bone_index = bone;
      req_element_index = elem;
      req_element_value = value;
      req_parent_bone = parent;
      req_matrix_count = mcount;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note(kind, bone, elem, value, parent, mcount);
      @(negedge clock);
   endtask

   // Waits until every owed response has arrived, then a short settle.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_bones(logic [6:0] count);
      drain();
      csr_bone_count = count;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.bone_count = count;
   endtask

   // Loads the form matrix and the first bones completely.
   task automatic fill_bones(int unsigned n);
      int unsigned nb;
      nb = sb.live_bones();
      for (int e = 0; e < 16; e++)
         send(REQ_FORM, $urandom, e, pick_value(), $urandom, $urandom);
      for (int b = 0; b < n; b++) begin
         for (int e = 0; e < 16; e++) begin
            send(REQ_RELATION, b, e, pick_value(), $urandom_range(0, nb - 1), $urandom);
            send(REQ_OWN, b, e, pick_value(), $urandom, $urandom);
         end
      end
   endtask

   // One random request, mostly addressing bones that exist.
   task automatic random_request();
      int unsigned nb;
      int unsigned ready;
      int unsigned pick;
      logic [5:0]  bone;
      logic [5:0]  parent;
      logic [6:0]  mcount;
      nb = sb.live_bones();
      ready = sb.ready_bones();
      bone = (nb > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, nb - 1) : $urandom;
      parent = (nb > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, nb - 1) : $urandom;
      mcount = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) send(REQ_RELATION, bone, $urandom, pick_value(), parent, mcount);
      else if (pick < 55) send(REQ_OWN, bone, $urandom, pick_value(), parent, mcount);
      else if (pick < 60) send(REQ_FORM, bone, $urandom, pick_value(), parent, mcount);
      else if (pick < 65) begin
         // A compute may only touch fully loaded matrices.
         if (nb == 0 || ready >= nb) send(REQ_COMPUTE, bone, $urandom, $urandom, parent, mcount);
         else if (ready > 0)
            send(REQ_COMPUTE, bone, $urandom, $urandom, parent, $urandom_range(0, ready));
         else send(REQ_FORM, bone, $urandom, pick_value(), parent, mcount);
      end
      else if (pick < 95) send(REQ_READ, bone, $urandom, $urandom, parent, mcount);
      else send(REQ_SPARE + $urandom_range(0, 2), bone, $urandom, $urandom, parent, mcount);
   endtask

   // Main sequence.
   initial begin
      logic [6:0] phase_bones [9];
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_bone_count = '0;
      req_valid = 1'b0;
      req_type = REQ_RELATION;
      req_bone_index = '0;
      req_element_index = '0;
      req_element_value = '0;
      req_parent_bone = '0;
      req_matrix_count = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty skeleton: everything but form loads is rejected.
      send(REQ_COMPUTE, 0, 0, 0, 0, 7'd64);
      send(REQ_READ, 0, 0, 0, 0, 0);
      send(REQ_RELATION, 0, 0, 1, 0, 0);
      send(REQ_OWN, 0, 0, 1, 0, 0);
      send(REQ_FORM, 6'h3F, 0, 32'h8000_0000, 6'h3F, 7'h7F);
      send(REQ_FORM, 0, 15, 32'h7FFF_FFFF, 0, 0);
      for (int k = 0; k < 3; k++) send(REQ_SPARE + k, 6'h3F, 4'hF, -1, 6'h3F, 7'h7F);

      // One bone: zero matrix count still computes the root.
      set_bones(7'd1);
      fill_bones(1);
      send(REQ_COMPUTE, 0, 0, 0, 0, 7'd0);
      send(REQ_READ, 0, 4'hF, 0, 0, 0);
      send(REQ_READ, 1, 0, 0, 0, 0);
      send(REQ_RELATION, 0, 0, 5, 1, 0);
      send(REQ_OWN, 6'h3F, 0, 5, 0, 0);
      send(REQ_COMPUTE, 0, 0, 0, 0, 7'h7F);
      send(REQ_READ, 0, 0, 0, 0, 0);

      // Random phases over several skeleton sizes.
      phase_bones = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd5, 7'd2, 7'd64, 7'd8, 7'd17};
      for (int ph = 0; ph < 9; ph++) begin
         set_bones(phase_bones[ph]);
         quiet = (ph == 4);
         if (sb.live_bones() > 0)
            fill_bones((sb.live_bones() < 2) ? sb.live_bones() : 2);
         for (int n = 0; n < 105; n++) begin
            if (ph == 2 && n == 100) drain();
            random_request();
         end
      end

      // Full skeleton with a longer chain of loaded bones.
      quiet = 1'b0;
      set_bones(7'd64);
      fill_bones(8);
      send(REQ_COMPUTE, 0, 0, 0, 0, 7'd8);
      for (int n = 0; n < 30; n++) send(REQ_READ, $urandom, $urandom, 0, 0, 0);
      send(REQ_COMPUTE, 0, 0, 0, 0, 7'd5);
      for (int n = 0; n < 30; n++) send(REQ_READ, $urandom, $urandom, 0, 0, 0);

      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
